@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the bit packer RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RSBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RSBP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rsbp_pkg.sv @@
// Package for the signed Rice bit packer.
// Holds the sequencer state type, command codes and the Rice parameter constants.
package rsbp_pkg;

  // Width and range of the Rice parameter register
  localparam int unsigned K_W    = 4;
  localparam int unsigned K_MAX  = 15;
  localparam logic [K_W-1:0] K_RESET = 4'd2;

  // Command codes
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENCODE,
    ST_FLUSH
  } state_e;

endpackage

@@ rtl/core/rsbp_shift_unit.sv @@
// Shared shift-and-merge unit of the bit packer.
// Shifts the pending word left and merges new low bits; depends on nothing else.
module rsbp_shift_unit #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned SH_W       = 6
) (
  input  logic [WORD_WIDTH-1:0] pend_i,
  input  logic [SH_W-1:0]       sh_i,
  input  logic [WORD_WIDTH-1:0] bits_i,
  output logic [WORD_WIDTH-1:0] res_o
);

  // Shift by the full width clears the word, which the append path relies on
  assign res_o = (pend_i << sh_i) | bits_i;

endmodule

@@ rtl/core/signed_rice_bit_packer.sv @@
// Signed Rice bit packer, top level.
// Depends on rsbp_pkg, rsbp_shift_unit and assert_macros.svh.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one transaction
// per command: cmd_i selects encode of value_i or flush of the partial word.
// The output channel (out_valid_o / out_stall_i) carries packed words, first
// code bit in the MSB, with valid_bits_o and last_o on the final word of a
// command. cfg_we_i / cfg_wdata_i write the Rice parameter k while idle.
// Encode: accept, then one step of the shared shifter per piece of the code:
// up to two steps for the remainder (none when k is 0), one per word the
// unary run touches, and one for the stop bit. Flush: accept, then one
// shifter step. The sequencer drives every step through the single
// shift-and-merge unit; the block takes one command at a time.
// Results sit in one output register. The sequencer keeps working while
// the receiver takes the held word; when the receiver stalls and the register
// is full, the sequencer holds until the word is taken. Reset empties the
// pending word, drops any held output and sets k to 2.
module signed_rice_bit_packer #(
  parameter int unsigned WORD_WIDTH  = 32,
  parameter int unsigned VALUE_WIDTH = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rsbp_pkg::K_W-1:0]              cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  cmd_i,
  input  logic signed [VALUE_WIDTH-1:0]         value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [WORD_WIDTH-1:0]                 word_o,
  output logic [$clog2(WORD_WIDTH+1)-1:0]       valid_bits_o,
  output logic                                  last_o
);

  import rsbp_pkg::*;

`include "assert_macros.svh"

  localparam int unsigned CNT_W  = $clog2(WORD_WIDTH + 1);
  localparam int unsigned CODE_W = (VALUE_WIDTH > K_MAX) ? VALUE_WIDTH : K_MAX;
  localparam int unsigned CMP_W  = (VALUE_WIDTH > CNT_W) ? VALUE_WIDTH : CNT_W;
  localparam int unsigned SUM_W  = CMP_W + 2;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WORD_WIDTH);

  state_e                  state_q, state_d;
  logic [K_W-1:0]          k_q;
  logic [WORD_WIDTH-1:0]   pend_q, pend_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CODE_W-1:0]       rem_q, rem_d;
  logic [K_W-1:0]          remcnt_q, remcnt_d;
  logic [VALUE_WIDTH-1:0]  ones_q, ones_d;
  logic                    zero_q, zero_d;

  logic                    out_valid_q;
  logic [WORD_WIDTH-1:0]   out_word_q;
  logic [CNT_W-1:0]        out_bits_q;
  logic                    out_last_q;

  logic                    slot_free;
  logic                    emit;
  logic [WORD_WIDTH-1:0]   emit_word;
  logic [CNT_W-1:0]        emit_bits;
  logic                    emit_last;

  logic [VALUE_WIDTH-1:0]  code;
  logic [CNT_W-1:0]        space;
  logic [CNT_W-1:0]        step_n;
  logic [K_W-1:0]          rem_sh;
  logic [CNT_W-1:0]        sh_amt;
  logic [WORD_WIDTH-1:0]   sh_bits;
  logic [WORD_WIDTH-1:0]   sh_res;
  logic [CNT_W-1:0]        cnt_new;
  logic [SUM_W-1:0]        rest;

  // Map the signed value to its unsigned code
  assign code  = {value_i[VALUE_WIDTH-2:0], 1'b0} ^ {VALUE_WIDTH{value_i[VALUE_WIDTH-1]}};
  assign space = FULL_CNT - cnt_q;
  assign slot_free = !out_valid_q || !out_stall_i;

  rsbp_shift_unit #(
    .WORD_WIDTH (WORD_WIDTH),
    .SH_W       (CNT_W)
  ) u_shift (
    .pend_i (pend_q),
    .sh_i   (sh_amt),
    .bits_i (sh_bits),
    .res_o  (sh_res)
  );

  // Sequencer: next state, step control and word emission
  always_comb begin
    state_d   = state_q;
    pend_d    = pend_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    remcnt_d  = remcnt_q;
    ones_d    = ones_q;
    zero_d    = zero_q;
    emit      = 1'b0;
    emit_word = sh_res;
    emit_bits = FULL_CNT;
    emit_last = 1'b0;
    step_n    = '0;
    rem_sh    = '0;
    sh_amt    = '0;
    sh_bits   = '0;
    cnt_new   = cnt_q;
    rest      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_FLUSH) begin
            state_d = ST_FLUSH;
          end else begin
            rem_d    = CODE_W'(code) & ~({CODE_W{1'b1}} << k_q);
            remcnt_d = k_q;
            ones_d   = code >> k_q;
            zero_d   = 1'b1;
            state_d  = ST_ENCODE;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          // Left-align the partial word through the shared shifter
          sh_amt = space;
          if (cnt_q != '0) begin
            emit      = 1'b1;
            emit_word = sh_res;
            emit_bits = cnt_q;
            emit_last = 1'b1;
          end
          pend_d  = '0;
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_ENCODE: begin
        if (slot_free) begin
          if (remcnt_q != '0) begin
            // Take the next remainder bits, MSB first
            if (CNT_W'(remcnt_q) > space) begin
              step_n = space;
            end else begin
              step_n = CNT_W'(remcnt_q);
            end
            rem_sh   = remcnt_q - K_W'(step_n);
            sh_bits  = WORD_WIDTH'(rem_q >> rem_sh);
            rem_d    = rem_q & ~({CODE_W{1'b1}} << rem_sh);
            remcnt_d = rem_sh;
          end else if (ones_q != '0) begin
            // Append a run of unary ones
            if (CMP_W'(ones_q) >= CMP_W'(space)) begin
              step_n = space;
            end else begin
              step_n = CNT_W'(ones_q);
            end
            sh_bits = ~({WORD_WIDTH{1'b1}} << step_n);
            ones_d  = ones_q - VALUE_WIDTH'(step_n);
          end else begin
            // Append the stop bit
            step_n  = CNT_W'(1);
            sh_bits = '0;
            zero_d  = 1'b0;
          end
          sh_amt  = step_n;
          cnt_new = cnt_q + step_n;
          rest    = SUM_W'(remcnt_d) + SUM_W'(ones_d) + SUM_W'(zero_d);
          if (cnt_new == FULL_CNT) begin
            emit      = 1'b1;
            emit_word = sh_res;
            emit_bits = FULL_CNT;
            emit_last = (rest < SUM_W'(WORD_WIDTH));
            pend_d    = '0;
            cnt_d     = '0;
          end else begin
            pend_d = sh_res;
            cnt_d  = cnt_new;
          end
          if (remcnt_d == '0 && ones_d == '0 && !zero_d) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state, the pending word, the output valid flag and the Rice parameter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= K_RESET;
      pend_q      <= '0;
      cnt_q       <= '0;
      remcnt_q    <= '0;
      ones_q      <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      cnt_q    <= cnt_d;
      remcnt_q <= remcnt_d;
      ones_q   <= ones_d;
      zero_q   <= zero_d;
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the output register and remainder payload
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (emit) begin
      out_word_q <= emit_word;
      out_bits_q <= emit_bits;
      out_last_q <= emit_last;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign word_o       = out_word_q;
  assign valid_bits_o = out_bits_q;
  assign last_o       = out_last_q;

  `RSBP_ASSERT(a_cnt_below_word, cnt_q < FULL_CNT, "pending count reached word width")
  `RSBP_ASSERT_IMP(a_out_bits_nonzero, out_valid_q, out_bits_q != '0,
                   "output word carries no valid bits")
  `RSBP_ASSERT_IMP(a_step_fits, state_q == ST_ENCODE && slot_free,
                   step_n != '0 && step_n <= space, "encode step does not fit pending word")
  `RSBP_ASSERT_IMP(a_emit_slot_free, emit, slot_free, "word emitted into an occupied output")

endmodule

@@ tb/signed_rice_bit_packer_tb.sv @@
// Testbench for signed_rice_bit_packer: directed and random encode/flush transactions.
// Predicts the packed output words in-bench and checks each output transaction against them.
// Depends on rsbp_pkg and the signed_rice_bit_packer RTL.
`timescale 1ns / 100ps

module signed_rice_bit_packer_tb;
  import rsbp_pkg::*;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned VALUE_W = 10;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic [5:0]        valid_bits;
    logic              last;
  } packed_word_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [K_W-1:0]            cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic                      cmd_i;
  logic signed [VALUE_W-1:0] value_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [WORD_W-1:0]         word_o;
  logic [5:0]                valid_bits_o;
  logic                      last_o;

  // Predicted packer state
  logic [WORD_W-1:0] shadow_bits;
  int unsigned       shadow_count;
  logic [K_W-1:0]    shadow_k;

  packed_word_t packed_word_q[$];
  int unsigned  mismatches;
  bit           idle_en;

  signed_rice_bit_packer #(
    .WORD_WIDTH (WORD_W),
    .VALUE_WIDTH(VALUE_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_o      (word_o),
    .valid_bits_o(valid_bits_o),
    .last_o      (last_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Append one code bit; push a full word when it fills
  function automatic void push_code_bit(bit b);
    packed_word_t w;
    shadow_bits  = {shadow_bits[WORD_W-2:0], b};
    shadow_count = shadow_count + 1;
    if (shadow_count == WORD_W) begin
      w.word       = shadow_bits;
      w.valid_bits = 6'(WORD_W);
      w.last       = 1'b0;
      packed_word_q.push_back(w);
      shadow_bits  = '0;
      shadow_count = 0;
    end
  endfunction

  // Predict the words caused by one accepted transaction
  function automatic void rice_pack(logic c, logic signed [VALUE_W-1:0] v);
    int unsigned  n_before;
    int           code;
    int           quot;
    packed_word_t w;
    n_before = packed_word_q.size();
    if (c == CMD_FLUSH) begin
      if (shadow_count > 0) begin
        w.word       = shadow_bits << (WORD_W - shadow_count);
        w.valid_bits = 6'(shadow_count);
        w.last       = 1'b0;
        packed_word_q.push_back(w);
        shadow_bits  = '0;
        shadow_count = 0;
      end
    end else begin
      if (v < 0) code = 2 * (-int'(v)) - 1;
      else       code = 2 * int'(v);
      for (int j = int'(shadow_k) - 1; j >= 0; j--) push_code_bit(code[j]);
      quot = code >> shadow_k;
      repeat (quot) push_code_bit(1'b1);
      push_code_bit(1'b0);
    end
    // Tag the final word of this transaction
    if (packed_word_q.size() > n_before) begin
      w = packed_word_q.pop_back();
      w.last = 1'b1;
      packed_word_q.push_back(w);
    end
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_residual();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12)      return VALUE_W'(int'($urandom_range(0, 16)) - 8);
    else if (sel < 17) return VALUE_W'(int'($urandom_range(0, 128)) - 64);
    else               return VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
  endfunction

  // Send one transaction; predict at the accepting edge
  task automatic send_item(logic c, logic signed [VALUE_W-1:0] v);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    rice_pack(c, v);
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) send_item(CMD_FLUSH, rand_residual());
      else                           send_item(CMD_ENCODE, rand_residual());
    end
  endtask

  // Hold the input idle until every predicted word has arrived
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (packed_word_q.size() != 0);
  endtask

  // Write k once the block is idle; an encode with no output may still be in flight
  task automatic set_rice_k(logic [K_W-1:0] k);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_wdata_i <= k;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_k     = k;
  endtask

  // Reset value of k, sign and magnitude extremes, flush on empty
  task automatic test_reset_k();
    int vals[8];
    vals = '{0, 1, -1, 2, -2, 511, -511, -512};
    foreach (vals[i]) send_item(CMD_ENCODE, VALUE_W'(vals[i]));
    send_item(CMD_FLUSH, '0);
    send_item(CMD_FLUSH, '0);
  endtask

  // Smallest and largest k, including the longest unary run
  task automatic test_k_extremes();
    set_rice_k(4'd0);
    send_item(CMD_ENCODE, VALUE_W'(-512));
    send_item(CMD_ENCODE, VALUE_W'(511));
    send_item(CMD_FLUSH, '0);
    set_rice_k(4'(K_MAX));
    send_item(CMD_ENCODE, '0);
    send_item(CMD_ENCODE, VALUE_W'(-1));
    send_item(CMD_ENCODE, VALUE_W'(511));
    send_item(CMD_FLUSH, '0);
  endtask

  // Flush with nothing pending, one pending bit, and a nonzero ignored value
  task automatic test_flush_cases();
    set_rice_k(4'd0);
    send_item(CMD_FLUSH, VALUE_W'(-1));
    send_item(CMD_ENCODE, '0);
    send_item(CMD_FLUSH, VALUE_W'(511));
    send_item(CMD_FLUSH, VALUE_W'(-512));
    send_item(CMD_ENCODE, VALUE_W'(-1));
    send_item(CMD_FLUSH, VALUE_W'(85));
  endtask

  // Random transactions across several k settings, idling on and off
  task automatic test_random_phases();
    logic [K_W-1:0] ks[9];
    ks = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd2, 4'd5, 4'd11, 4'd0};
    ks[8] = K_W'($urandom_range(0, K_MAX));
    foreach (ks[p]) begin
      set_rice_k(ks[p]);
      idle_en = (p % 3 != 2);
      send_random(45);
    end
    idle_en = 1'b1;
  endtask

  // Sender pauses mid-stream until all output has drained
  task automatic test_drain_pause();
    set_rice_k(4'd4);
    send_random(10);
    wait_drained();
    send_random(10);
  endtask

  // Closing stretch with no idling on either side
  task automatic test_no_idle_tail();
    set_rice_k(K_W'($urandom_range(0, K_MAX)));
    idle_en = 1'b0;
    send_random(30);
    send_item(CMD_FLUSH, '0);
  endtask

  // Receiver stall in random bursts
  initial begin
    int hold;
    hold = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) hold--;
      else if (idle_en && $urandom_range(0, 4) == 0) hold = $urandom_range(1, 9);
      out_stall_i <= (hold > 0);
    end
  end

  // Compare each output transaction with the oldest predicted word
  always @(posedge clk_i) begin
    packed_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (packed_word_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t unexpected word %h bits %0d last %0b",
                   $realtime, word_o, valid_bits_o, last_o);
      end else begin
        w = packed_word_q.pop_front();
        if (word_o !== w.word || valid_bits_o !== w.valid_bits || last_o !== w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t mismatch: expected word %h bits %0d last %0b, got %h %0d %0b",
                     $realtime, w.word, w.valid_bits, w.last,
                     word_o, valid_bits_o, last_o);
        end
      end
    end
  end

  // Main sequence
  initial begin
    mismatches   = 0;
    idle_en      = 1'b1;
    shadow_bits  = '0;
    shadow_count = 0;
    shadow_k     = K_RESET;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    cmd_i       <= CMD_ENCODE;
    value_i     <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_k();
    test_k_extremes();
    test_flush_cases();
    test_random_phases();
    test_drain_pause();
    test_no_idle_tail();

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && packed_word_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
